// ----- src/dbls_pkg.sv -----
// ----------------------------------------------------------------------------
// dbls_pkg: shared types and constants of the LED strip streamer
// Frame geometry, widths, reset values and configuration register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package dbls_pkg;

    // Strip geometry
    localparam int LED_COUNT   = 1024;
    localparam int FRAME_BYTES = 3 * LED_COUNT;
    localparam int STORE_BYTES = 2 * FRAME_BYTES;

    // Widths
    localparam int BYTE_W     = 8;
    localparam int STORE_AW   = $clog2(STORE_BYTES);
    localparam int POS_W      = $clog2(FRAME_BYTES + 1);
    localparam int TIMEOUT_W  = 16;
    localparam int LATCH_W    = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    typedef logic [BYTE_W-1:0] data_byte_t;

    // Byte values and reset values
    localparam data_byte_t PIXEL_FLAG  = 8'h80;
    localparam data_byte_t LATCH_BYTE  = 8'h00;
    localparam data_byte_t CLEAR_VALUE = 8'h0F;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd100;
    localparam logic [LATCH_W-1:0]   LATCH_RESET   = 8'd48;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TIMEOUT_MS       = 1'b0,
        REG_LATCH_ZERO_BYTES = 1'b1
    } cfg_reg_t;

endpackage : dbls_pkg

`default_nettype wire

// ----- src/dbls_item_if.sv -----
// ----------------------------------------------------------------------------
// dbls_item_if: input item channel
// One event slot: received byte, transmitter ready and millisecond tick.
// ----------------------------------------------------------------------------
`default_nettype none

interface dbls_item_if
    import dbls_pkg::*;
;
    logic       valid;
    logic       ready;
    logic       rx_valid;
    data_byte_t rx_byte;
    logic       tx_ready;
    logic       ms_tick;

    modport source (output valid, output rx_valid, output rx_byte,
                    output tx_ready, output ms_tick, input ready);
    modport sink   (input valid, input rx_valid, input rx_byte,
                    input tx_ready, input ms_tick, output ready);
endinterface : dbls_item_if

`default_nettype wire

// ----- src/dbls_result_if.sv -----
// ----------------------------------------------------------------------------
// dbls_result_if: result item channel
// Transmit byte plus frame swap and timeout flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface dbls_result_if
    import dbls_pkg::*;
;
    logic       valid;
    logic       ready;
    logic       tx_valid;
    data_byte_t tx_byte;
    logic       frame_swapped;
    logic       timed_out;

    modport source (output valid, output tx_valid, output tx_byte,
                    output frame_swapped, output timed_out, input ready);
    modport sink   (input valid, input tx_valid, input tx_byte,
                    input frame_swapped, input timed_out, output ready);
endinterface : dbls_result_if

`default_nettype wire

// ----- src/double_buffered_led_strip_streamer.sv -----
// ----------------------------------------------------------------------------
// double_buffered_led_strip_streamer: double-buffered LED strip byte streamer
// Received bytes fill the back frame buffer; transmit slots send the front
// buffer with bit 7 set, followed by a run of latch zeros.
//
// Usage:
//   item_chan   : one item per event slot (rx byte, tx ready, ms tick).
//   result_chan : one result per item (tx byte, swap and timeout flags).
//   cfg port    : cfg_wr_en / cfg_index / cfg_data, written while idle.
// Pipeline: state and frame memory are read into the first stage at the
//   accept edge, then an output stage registers the result.
// Throughput: one item per cycle when not stalled; the frame memory has one
//   write and one read port; reads (front half) never hit writes (back half).
// Reset: all control state returns to its reset value, then a clearing
//   pass writes 0x0F to all 2*FRAME_BYTES memory entries, one per cycle;
//   item_chan.ready stays low meanwhile.
//   Configuration writes are taken during the pass.
// Stall: up to two items are held in the pipeline; when both stages are
//   full and result_chan.ready is low, item_chan.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module double_buffered_led_strip_streamer
    import dbls_pkg::*;
(
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   cfg_wr_en,
    input  wire [CFG_IDX_W-1:0]   cfg_index,
    input  wire [CFG_DATA_W-1:0]  cfg_data,
    dbls_item_if.sink             item_chan,
    dbls_result_if.source         result_chan
);

    // First pipeline stage contents
    typedef struct packed {
        logic tx_valid;
        logic pixel;
        logic swapped;
        logic timed;
    } stage_t;

    // Configuration
    logic [TIMEOUT_W-1:0] timeout_ms_reg;
    logic [LATCH_W-1:0]   latch_zero_bytes_reg;

    // Streamer state
    logic                 front_select_reg,  front_select_next;
    logic [POS_W-1:0]     fill_pos_reg,      fill_pos_next;
    logic [POS_W-1:0]     send_pos_reg,      send_pos_next;
    logic                 sending_zeros_reg, sending_zeros_next;
    logic [LATCH_W-1:0]   zeros_left_reg,    zeros_left_next;
    logic [TIMEOUT_W-1:0] ms_left_reg,       ms_left_next;

    // Clearing pass
    logic                 clr_busy_reg;
    logic [STORE_AW-1:0]  clr_addr_reg;

    // Pipeline
    logic                 s1_valid_reg;
    stage_t               s1_reg, s1_next;
    logic                 out_valid_reg;
    logic                 out_tx_valid_reg;
    data_byte_t           out_tx_byte_reg;
    logic                 out_swapped_reg;
    logic                 out_timed_reg;

    // Frame memory
    data_byte_t           frame_mem [STORE_BYTES];
    data_byte_t           mem_rdata_reg;
    logic                 mem_we;
    logic                 mem_re;
    logic [STORE_AW-1:0]  mem_waddr;
    logic [STORE_AW-1:0]  mem_raddr;
    data_byte_t           mem_wdata;
    logic [STORE_AW-1:0]  rx_addr;

    logic                 accept;
    logic                 s1_adv;
    logic [POS_W-1:0]     send_pos_inc;
    logic [POS_W-1:0]     fill_pos_inc;
    logic [LATCH_W-1:0]   zeros_dec;
    logic [TIMEOUT_W-1:0] ms_dec;

    // Handshake
    assign s1_adv          = s1_valid_reg && (!out_valid_reg || result_chan.ready);
    assign item_chan.ready = !clr_busy_reg && (!s1_valid_reg || s1_adv);
    assign accept          = item_chan.valid && item_chan.ready;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_ms_reg       <= TIMEOUT_RESET;
            latch_zero_bytes_reg <= LATCH_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_TIMEOUT_MS:       timeout_ms_reg       <= cfg_data[TIMEOUT_W-1:0];
                REG_LATCH_ZERO_BYTES: latch_zero_bytes_reg <= cfg_data[LATCH_W-1:0];
                default:              ;
            endcase
        end
    end

    // Memory addresses: writer reads the front half, receiver writes the back
    assign mem_raddr = front_select_reg
                     ? STORE_AW'(FRAME_BYTES) + STORE_AW'(send_pos_reg)
                     : STORE_AW'(send_pos_reg);
    assign rx_addr   = front_select_reg
                     ? STORE_AW'(fill_pos_reg)
                     : STORE_AW'(FRAME_BYTES) + STORE_AW'(fill_pos_reg);

    assign send_pos_inc = send_pos_reg + POS_W'(1);
    assign fill_pos_inc = fill_pos_reg + POS_W'(1);
    assign zeros_dec    = zeros_left_reg - LATCH_W'(1);
    assign ms_dec       = ms_left_reg - TIMEOUT_W'(1);

    // Per-item state update: writer, then timeout, then receiver
    always_comb
    begin
        front_select_next  = front_select_reg;
        fill_pos_next      = fill_pos_reg;
        send_pos_next      = send_pos_reg;
        sending_zeros_next = sending_zeros_reg;
        zeros_left_next    = zeros_left_reg;
        ms_left_next       = ms_left_reg;
        s1_next            = '0;

        // writer
        if (item_chan.tx_ready)
        begin
            s1_next.tx_valid = 1'b1;
            if (!sending_zeros_reg)
            begin
                s1_next.pixel = 1'b1;
                send_pos_next = send_pos_inc;
                if (send_pos_inc == POS_W'(FRAME_BYTES))
                begin
                    sending_zeros_next = 1'b1;
                    zeros_left_next    = latch_zero_bytes_reg;
                end
            end
            else
            begin
                zeros_left_next = zeros_dec;
                if (zeros_dec == '0)
                begin
                    sending_zeros_next = 1'b0;
                    send_pos_next      = '0;
                end
            end
        end

        // idle timeout
        if (item_chan.ms_tick)
        begin
            ms_left_next = ms_dec;
            if (ms_dec == '0)
            begin
                s1_next.timed = 1'b1;
                fill_pos_next = '0;
                ms_left_next  = timeout_ms_reg;
            end
        end

        // receiver; a timeout in the same item restarts at position 0
        if (item_chan.rx_valid)
        begin
            ms_left_next = timeout_ms_reg;
            if (s1_next.timed)
                fill_pos_next = POS_W'(1);
            else if (fill_pos_inc == POS_W'(FRAME_BYTES))
            begin
                front_select_next = !front_select_reg;
                fill_pos_next     = '0;
                s1_next.swapped   = 1'b1;
            end
            else
                fill_pos_next = fill_pos_inc;
        end
    end

    // Receiver write address follows a same-item timeout
    assign mem_we    = clr_busy_reg || (accept && item_chan.rx_valid);
    assign mem_waddr = clr_busy_reg ? clr_addr_reg
                     : (s1_next.timed ? (front_select_reg ? '0 : STORE_AW'(FRAME_BYTES))
                                      : rx_addr);
    assign mem_wdata = clr_busy_reg ? CLEAR_VALUE : item_chan.rx_byte;
    assign mem_re    = accept && s1_next.pixel;

    // Frame memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            frame_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            mem_rdata_reg <= frame_mem[mem_raddr];
    end

    // Clearing pass after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_addr_reg <= clr_addr_reg + STORE_AW'(1);
            if (clr_addr_reg == STORE_AW'(STORE_BYTES - 1))
                clr_busy_reg <= 1'b0;
        end
    end

    // Streamer state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_select_reg  <= 1'b0;
            fill_pos_reg      <= '0;
            send_pos_reg      <= '0;
            sending_zeros_reg <= 1'b1;
            zeros_left_reg    <= LATCH_RESET;
            ms_left_reg       <= TIMEOUT_RESET;
        end
        else if (accept)
        begin
            front_select_reg  <= front_select_next;
            fill_pos_reg      <= fill_pos_next;
            send_pos_reg      <= send_pos_next;
            sending_zeros_reg <= sending_zeros_next;
            zeros_left_reg    <= zeros_left_next;
            ms_left_reg       <= ms_left_next;
        end
    end

    // Pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;

            if (s1_adv)
                out_valid_reg <= 1'b1;
            else if (result_chan.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Pipeline payload
    always_ff @(posedge clk)
    begin
        if (accept)
            s1_reg <= s1_next;
        if (s1_adv)
        begin
            out_tx_valid_reg <= s1_reg.tx_valid;
            out_tx_byte_reg  <= s1_reg.pixel ? (PIXEL_FLAG | mem_rdata_reg) : LATCH_BYTE;
            out_swapped_reg  <= s1_reg.swapped;
            out_timed_reg    <= s1_reg.timed;
        end
    end

    assign result_chan.valid         = out_valid_reg;
    assign result_chan.tx_valid      = out_tx_valid_reg;
    assign result_chan.tx_byte       = out_tx_byte_reg;
    assign result_chan.frame_swapped = out_swapped_reg;
    assign result_chan.timed_out     = out_timed_reg;

    // Checks
    a_no_accept_while_clearing: assert property (
        @(posedge clk) disable iff (!rst_n)
        clr_busy_reg |-> !item_chan.ready)
        else $error("item accepted during clearing pass");

    a_fill_in_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        fill_pos_reg < POS_W'(FRAME_BYTES))
        else $error("fill position out of frame");

    a_send_in_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        !sending_zeros_reg |-> send_pos_reg < POS_W'(FRAME_BYTES))
        else $error("send position out of frame");

    a_pixel_flag: assert property (
        @(posedge clk) disable iff (!rst_n)
        (s1_adv && s1_reg.pixel) |=> result_chan.tx_byte[BYTE_W-1])
        else $error("pixel byte without flag bit");

endmodule : double_buffered_led_strip_streamer

`default_nettype wire
